// ----- design/hwb_pkg.sv -----
// Shared types and constants for the harmonic wavetable builder.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package hwb_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_HARMONIC_COUNT = 2'd0;
  localparam logic [1:0] CFG_WAVE_TYPE      = 2'd1;
  localparam logic [1:0] CFG_PHASE_OFFSET   = 2'd2;

  // Wave type codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SAW    = 3'd1;
  localparam logic [2:0] WAVE_SQUARE = 3'd2;
  localparam logic [2:0] WAVE_BUZZ   = 3'd3;

  // Request kinds
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // 1.0 in the Q9.15 accumulator format
  localparam logic signed [23:0] ONE_Q15 = 24'sd32768;

  // Shared divider geometry: quotient always below 2^17
  localparam int DIV_NW = 41;
  localparam int DIV_DW = 25;
  localparam int DIV_QW = 17;

  typedef struct packed {
    logic [7:0]  harmonic_count;
    logic [2:0]  wave_type;
    logic [15:0] phase_offset;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_go;
    logic build_init;
    logic ent_init;
    logic rom_rd;
    logic sine_wr;
    logic h_acc;
    logic div_ld_h;
    logic div_ld_n;
    logic div_step;
    logic ent_end;
    logic sums_rd;
    logic nrm_wr;
    logic i_inc;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic type_bad;
    logic type_sine;
    logic type_buzz;
    logic n_over;
    logic i_last;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/harmonic_wavetable_builder_top.sv -----
// Top level of the harmonic wavetable builder: configuration registers,
// controller and datapath. Depends on hwb_pkg, hwb_ctrl and hwb_dpath.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+------------------------
//  request  | start, in_kind, in_read_index          | taken when start & !busy
//  result   | out_valid, out_sample, out_status      | one-cycle strobe
//  config   | cfg_we, cfg_index, cfg_wdata           | written when cfg_we
//
// A read returns its result on the cycle after it is taken; reads can be
// issued every cycle while no build is in progress. A saw or square build
// passes each harmonic it sums through the shared bit-serial divider, then
// divides every entry once more to normalize; buzz sums its harmonics
// undivided but normalizes the same way, sine writes one lookup per entry,
// and an unsupported type ends at once; the divider paces the other builds.
// Reset leaves the table reading all zeros; no clearing pass is needed.
// Results cannot be stalled; busy is high throughout a build.
`default_nettype none
module harmonic_wavetable_builder_top #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int SINE_ROM_DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_kind,
  input  wire logic [$clog2(TABLE_DEPTH):0]   in_read_index,
  output logic                                out_valid,
  output logic signed [15:0]                  out_sample,
  output logic                                out_status,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [15:0]                    cfg_wdata
);

  hwb_pkg::cfg_t cfg_r;
  hwb_pkg::cmd_t cmd;
  hwb_pkg::sts_t sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.harmonic_count <= 8'd1;
      cfg_r.wave_type      <= hwb_pkg::WAVE_SINE;
      cfg_r.phase_offset   <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        hwb_pkg::CFG_HARMONIC_COUNT: cfg_r.harmonic_count <= cfg_wdata[7:0];
        hwb_pkg::CFG_WAVE_TYPE:      cfg_r.wave_type      <= cfg_wdata[2:0];
        hwb_pkg::CFG_PHASE_OFFSET:   cfg_r.phase_offset   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_kind),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  hwb_dpath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .rd_index (in_read_index),
    .sts      (sts),
    .sample   (out_sample),
    .status   (out_status)
  );

  // A build request holds off further requests
  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == hwb_pkg::KIND_BUILD) |=> busy)
    else $error("build request did not raise busy");

  // A read request is answered on the next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == hwb_pkg::KIND_READ) |=> out_valid)
    else $error("read request without result");

  // A build result ends the busy period
  a_build_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && busy |=> !busy)
    else $error("busy held after build result");

  // Build results carry a zero sample
  a_build_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && busy |-> out_sample == 16'sd0)
    else $error("nonzero sample on build result");

endmodule
`default_nettype wire

// ----- design/hwb_sine_rom.sv -----
// Quarter-wave sine ROM, SINE_ROM_DEPTH+1 entries in Q1.15, registered read.
// Contents are computed at elaboration by a Taylor series; no dependencies.
`default_nettype none
module hwb_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH):0]     rd_addr,
  output logic      [15:0]                rd_data
);

  localparam int LG = $clog2(DEPTH);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(pi/2*k/DEPTH) in Q1.15 from a 7-term series in Q30
  function automatic logic [15:0] sine_entry(input logic [15:0] k);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    logic signed [63:0] acc;
    t    = ({48'd0, k} << 30) >> LG;
    x    = (t * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; acc = acc + $signed(term);
    if (acc < 0) begin
      acc = 64'sd0;
    end
    r = ($unsigned(acc) + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

  logic [15:0] tab [0:DEPTH];

  for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
    assign tab[g] = sine_entry(16'(g));
  end

  // Registered lookup
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tab[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/hwb_div.sv -----
// Restoring divider, one quotient bit per cycle while step is high, shared
// by harmonic weighting and peak normalization. Depends on hwb_pkg.
`default_nettype none
module hwb_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         ld,
  input  wire logic                         step,
  input  wire logic [hwb_pkg::DIV_NW-1:0]   num,
  input  wire logic [hwb_pkg::DIV_DW-1:0]   den,
  output logic      [hwb_pkg::DIV_QW-1:0]   quo,
  output logic                              last
);

  localparam int QW = hwb_pkg::DIV_QW;
  localparam int DW = hwb_pkg::DIV_DW;
  localparam int NW = hwb_pkg::DIV_NW;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r;
  logic [4:0]    cnt_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign last  = (cnt_r == 5'(QW - 1));
  assign quo   = q_r;

  // Next remainder and quotient bits
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (ld) begin
      rem_nxt = DW'(num[NW-1:QW]);
      q_nxt   = num[QW-1:0];
    end else if (step) begin
      rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      q_nxt   = {q_r[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (ld) begin
      den_r <= den;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ld) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 5'd1;
    end
  end

endmodule
`default_nettype wire

// ----- design/hwb_dpath.sv -----
// Datapath: phase accumulator, sine lookup, harmonic sums, peak tracking,
// sum and table memories. Depends on hwb_pkg, hwb_sine_rom and hwb_div.
`default_nettype none
module hwb_dpath #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int SINE_ROM_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire hwb_pkg::cfg_t                     cfg,
  input  wire hwb_pkg::cmd_t                     cmd,
  input  wire logic [$clog2(TABLE_DEPTH):0]      rd_index,
  output hwb_pkg::sts_t                          sts,
  output logic signed [15:0]                     sample,
  output logic                                   status
);

  localparam int LGD = $clog2(TABLE_DEPTH);
  localparam int LGR = $clog2(SINE_ROM_DEPTH);

  // Entry and harmonic counters, phase, sums
  logic [LGD-1:0]     i_r;
  logic [8:0]         n_r;
  logic [31:0]        ph_r;
  logic signed [23:0] acc_r;
  logic signed [23:0] peak_r;
  logic               neg_r;
  logic               err_r;
  logic               table_ok_r;
  logic               rd_ok_r;
  logic [15:0]        rd_q_r;
  logic signed [23:0] sums_q_r;

  logic signed [15:0] wave_mem [0:TABLE_DEPTH-1];
  logic signed [23:0] sums_mem [0:TABLE_DEPTH-1];

  // Phase increments for this entry
  logic [31:0] inc;
  logic [31:0] step_inc;
  logic        square;
  assign inc      = {i_r, {(32 - LGD){1'b0}}};
  assign square   = (cfg.wave_type == hwb_pkg::WAVE_SQUARE);
  assign step_inc = square ? {inc[30:0], 1'b0} : inc;

  // Sine lookup: quadrant fold of the top phase bits
  logic [LGR+1:0] pos;
  logic [LGR:0]   rom_addr;
  logic [15:0]    rom_q;
  logic           rneg_r;
  logic signed [16:0] s_w;
  assign pos      = ph_r[31 -: LGR + 2];
  assign rom_addr = pos[LGR] ? (LGR + 1)'(SINE_ROM_DEPTH - int'(pos[LGR-1:0]))
                             : {1'b0, pos[LGR-1:0]};
  assign s_w      = rneg_r ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  hwb_sine_rom #(.DEPTH(SINE_ROM_DEPTH)) u_rom (
    .clk     (clk),
    .rd_en   (cmd.rom_rd),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      rneg_r <= pos[LGR+1];
    end
  end

  // Divider operands
  logic [14:0] s_mag;
  logic [23:0] a_mag;
  logic [23:0] p_mag;
  logic [hwb_pkg::DIV_NW-1:0] div_num;
  logic [hwb_pkg::DIV_DW-1:0] div_den;
  logic [hwb_pkg::DIV_QW-1:0] quo;
  logic                       div_last;
  assign s_mag = s_w[16] ? 15'(-s_w) : s_w[14:0];
  assign a_mag = sums_q_r[23] ? 24'(-sums_q_r) : sums_q_r;
  assign p_mag = peak_r[23] ? 24'(-peak_r) : peak_r;

  always_comb begin
    if (cmd.div_ld_n) begin
      div_num = (hwb_pkg::DIV_NW'(a_mag) << 16) + hwb_pkg::DIV_NW'(p_mag);
      div_den = {1'b0, p_mag} << 1;
    end else begin
      div_num = hwb_pkg::DIV_NW'({s_mag, 1'b0}) + hwb_pkg::DIV_NW'(n_r);
      div_den = hwb_pkg::DIV_DW'({n_r, 1'b0});
    end
  end

  hwb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (cmd.div_ld_h | cmd.div_ld_n),
    .step  (cmd.div_step),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .last  (div_last)
  );

  // Harmonic term and normalized sample
  logic signed [23:0] term;
  logic signed [23:0] acc_mag_cmp;
  logic [23:0]        acc_mag;
  logic signed [15:0] nrm;
  always_comb begin
    if (cfg.wave_type == hwb_pkg::WAVE_BUZZ) begin
      term = 24'(s_w);
    end else begin
      term = neg_r ? -$signed({7'd0, quo}) : $signed({7'd0, quo});
    end
    acc_mag_cmp = acc_r;
    acc_mag     = acc_r[23] ? 24'(-acc_r) : acc_r;
    if (neg_r) begin
      nrm = 16'(-$signed({1'b0, quo}));
    end else begin
      nrm = (quo > 17'd32767) ? 16'sd32767 : $signed(quo[15:0]);
    end
  end

  // Counters and accumulators
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      i_r    <= '0;
      peak_r <= hwb_pkg::ONE_Q15;
    end else if (cmd.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.ent_init) begin
      acc_r <= '0;
      n_r   <= 9'd1;
      ph_r  <= {cfg.phase_offset, 16'd0} + inc;
    end else if (cmd.h_acc) begin
      acc_r <= acc_r + term;
      n_r   <= n_r + (square ? 9'd2 : 9'd1);
      ph_r  <= ph_r + step_inc;
    end
    if (cmd.ent_end && (p_mag < acc_mag)) begin
      peak_r <= acc_mag_cmp;
    end
    if (cmd.div_ld_h) begin
      neg_r <= s_w[16];
    end else if (cmd.div_ld_n) begin
      neg_r <= (sums_q_r[23] != peak_r[23]) && (a_mag != 24'd0);
    end
  end

  // Table and sum memories
  always_ff @(posedge clk) begin
    if (cmd.sine_wr) begin
      wave_mem[i_r] <= s_w[15:0];
    end else if (cmd.nrm_wr) begin
      wave_mem[i_r] <= nrm;
    end
    if (cmd.rd_go) begin
      rd_q_r <= wave_mem[(rd_index == (LGD + 1)'(TABLE_DEPTH)) ? '0 : rd_index[LGD-1:0]];
    end
    if (cmd.ent_end) begin
      sums_mem[i_r] <= acc_r;
    end
    if (cmd.sums_rd) begin
      sums_q_r <= sums_mem[i_r];
    end
  end

  // Flags; table reads zero until a supported build is accepted, and again after an unsupported one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r      <= 1'b0;
      table_ok_r <= 1'b0;
      rd_ok_r    <= 1'b0;
    end else begin
      rd_ok_r <= cmd.rd_go && (rd_index <= (LGD + 1)'(TABLE_DEPTH)) && table_ok_r;
      if (cmd.build_init) begin
        err_r      <= sts.type_bad;
        table_ok_r <= !sts.type_bad;
      end
    end
  end

  assign sample = rd_ok_r ? $signed(rd_q_r) : 16'sd0;
  assign status = err_r;

  // Status to the controller
  always_comb begin
    sts.type_bad  = (cfg.wave_type > hwb_pkg::WAVE_BUZZ);
    sts.type_sine = (cfg.wave_type == hwb_pkg::WAVE_SINE);
    sts.type_buzz = (cfg.wave_type == hwb_pkg::WAVE_BUZZ);
    sts.n_over    = (n_r > {1'b0, cfg.harmonic_count});
    sts.i_last    = (i_r == {LGD{1'b1}});
    sts.div_last  = div_last;
  end

endmodule
`default_nettype wire

// ----- design/hwb_ctrl.sv -----
// Controller state machine: sequences builds entry by entry and harmonic
// by harmonic, and passes reads. Depends on hwb_pkg.
`default_nettype none
module hwb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           kind,
  input  wire hwb_pkg::sts_t  sts,
  output hwb_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_ENT, S_SADDR, S_SWR, S_HCHK, S_HDATA, S_HDIV, S_HADD,
    S_HEND, S_NRD, S_NLD, S_NDIV, S_NWR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          if (kind == hwb_pkg::KIND_READ) begin
            cmd.rd_go = 1'b1;
          end else begin
            cmd.build_init = 1'b1;
            state_nxt = sts.type_bad ? S_DONE : S_ENT;
          end
        end
      end
      S_ENT: begin
        cmd.ent_init = 1'b1;
        state_nxt = sts.type_sine ? S_SADDR : S_HCHK;
      end
      S_SADDR: begin
        cmd.rom_rd = 1'b1;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        cmd.sine_wr = 1'b1;
        cmd.i_inc   = 1'b1;
        state_nxt = sts.i_last ? S_DONE : S_ENT;
      end
      S_HCHK: begin
        if (sts.n_over) begin
          state_nxt = S_HEND;
        end else begin
          cmd.rom_rd = 1'b1;
          state_nxt = S_HDATA;
        end
      end
      S_HDATA: begin
        if (sts.type_buzz) begin
          cmd.h_acc = 1'b1;
          state_nxt = S_HCHK;
        end else begin
          cmd.div_ld_h = 1'b1;
          state_nxt = S_HDIV;
        end
      end
      S_HDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_HADD;
        end
      end
      S_HADD: begin
        cmd.h_acc = 1'b1;
        state_nxt = S_HCHK;
      end
      S_HEND: begin
        cmd.ent_end = 1'b1;
        cmd.i_inc   = 1'b1;
        state_nxt = sts.i_last ? S_NRD : S_ENT;
      end
      S_NRD: begin
        cmd.sums_rd = 1'b1;
        state_nxt = S_NLD;
      end
      S_NLD: begin
        cmd.div_ld_n = 1'b1;
        state_nxt = S_NDIV;
      end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_NWR;
        end
      end
      S_NWR: begin
        cmd.nrm_wr = 1'b1;
        cmd.i_inc  = 1'b1;
        state_nxt = sts.i_last ? S_DONE : S_NRD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= cmd.rd_go || (state_nxt == S_DONE);
    end
  end

endmodule
`default_nettype wire

// ----- bench/hwb_checker.sv -----
// Checker for the harmonic wavetable builder: tracks register writes, predicts
// each result from the accepted requests and compares. Depends on hwb_pkg.
module hwb_checker #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int SINE_ROM_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic                         in_kind,
  input  wire logic [$clog2(TABLE_DEPTH):0] in_read_index,
  input  wire logic                         out_valid,
  input  wire logic signed [15:0]           out_sample,
  input  wire logic                         out_status,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_wdata,
  output int                                fail_count,
  output int                                pending
);

  typedef longint unsigned u64_t;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  typedef struct {
    logic signed [15:0] sample;
    logic               status;
  } entry_result_t;

  // Predicted block state
  logic [15:0]        quarter_sine [SINE_ROM_DEPTH+1];
  logic signed [15:0] table_model [TABLE_DEPTH+1];
  int                 sum_model [TABLE_DEPTH];
  int                 peak_model;
  logic               err_model;
  hwb_pkg::cfg_t      cfg_model;
  entry_result_t      expected_q[$];

  assign pending = expected_q.size();

  // Quarter-wave sine in Q1.15 from a Taylor series in Q30
  function automatic void fill_quarter_sine();
    u64_t t, x, x2, term, r;
    longint acc;
    for (int k = 0; k <= SINE_ROM_DEPTH; k++) begin
      t = (longint'(k) << 30) / SINE_ROM_DEPTH;
      x = (t * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int j = 1; j <= 6; j++) begin
        term = ((term * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
        if (j % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      r = (u64_t'(acc) + 16384) >> 15;
      quarter_sine[k] = (r > 32767) ? 16'd32767 : r[15:0];
    end
  endfunction

  function automatic int sine_lookup(logic [31:0] phase);
    u64_t p;
    int q, k, v;
    p = (u64_t'(phase) * (4 * SINE_ROM_DEPTH)) >> 32;
    q = int'(p / SINE_ROM_DEPTH) & 3;
    k = int'(p % SINE_ROM_DEPTH);
    v = (q & 1) ? int'(quarter_sine[SINE_ROM_DEPTH - k]) : int'(quarter_sine[k]);
    return (q & 2) ? -v : v;
  endfunction

  function automatic logic [31:0] harmonic_phase(int n, int i);
    u64_t base;
    base = (u64_t'(n * i) << 32) / TABLE_DEPTH;
    return base[31:0] + {cfg_model.phase_offset, 16'd0};
  endfunction

  // Division with rounding to nearest, ties away from zero
  function automatic int scaled_term(int s, int n);
    int mag, q;
    mag = (s < 0) ? -s : s;
    q = (2 * mag + n) / (2 * n);
    return (s < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] normalized(int a, int p);
    longint am, pm, q;
    am = (a < 0) ? -longint'(a) : longint'(a);
    pm = (p < 0) ? -longint'(p) : longint'(p);
    q = ((am << 16) + pm) / (2 * pm);
    if (((a < 0) != (p < 0)) && am != 0) begin
      if (q > 32768) q = 32768;
      return 16'(-q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  function automatic void build_table();
    int acc, am, pm, stride;
    peak_model = 32'sd32768;
    if (cfg_model.wave_type > hwb_pkg::WAVE_BUZZ) begin
      foreach (table_model[i]) table_model[i] = '0;
      err_model = 1'b1;
      return;
    end
    err_model = 1'b0;
    if (cfg_model.wave_type == hwb_pkg::WAVE_SINE) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        table_model[i] = 16'(sine_lookup(harmonic_phase(1, i)));
    end else begin
      stride = (cfg_model.wave_type == hwb_pkg::WAVE_SQUARE) ? 2 : 1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        acc = 0;
        for (int n = 1; n <= cfg_model.harmonic_count; n += stride) begin
          if (cfg_model.wave_type == hwb_pkg::WAVE_BUZZ)
            acc += sine_lookup(harmonic_phase(n, i));
          else
            acc += scaled_term(sine_lookup(harmonic_phase(n, i)), n);
        end
        am = (acc < 0) ? -acc : acc;
        pm = (peak_model < 0) ? -peak_model : peak_model;
        if (pm < am) peak_model = acc;
        sum_model[i] = acc;
      end
      for (int i = 0; i < TABLE_DEPTH; i++)
        table_model[i] = normalized(sum_model[i], peak_model);
    end
    table_model[TABLE_DEPTH] = table_model[0];
  endfunction

  // Watch the three channels
  always @(posedge clk) begin
    entry_result_t exp_r;
    if (!rst_n) begin
      fill_quarter_sine();
      foreach (table_model[i]) table_model[i] = '0;
      peak_model = 32768;
      err_model = 1'b0;
      cfg_model.harmonic_count = 8'd1;
      cfg_model.wave_type = hwb_pkg::WAVE_SINE;
      cfg_model.phase_offset = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result sample=%0d status=%0d", $time,
                   out_sample, out_status);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_sample !== exp_r.sample) begin
            $display("%0t: sample mismatch expected=%0d actual=%0d", $time,
                     exp_r.sample, out_sample);
            fail_count++;
          end
          if (out_status !== exp_r.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                     exp_r.status, out_status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        exp_r.sample = '0;
        if (in_kind == hwb_pkg::KIND_BUILD) build_table();
        else if (in_read_index <= TABLE_DEPTH) exp_r.sample = table_model[in_read_index];
        exp_r.status = err_model;
        expected_q.push_back(exp_r);
      end
      if (cfg_we) begin
        case (cfg_index)
          hwb_pkg::CFG_HARMONIC_COUNT: cfg_model.harmonic_count = cfg_wdata[7:0];
          hwb_pkg::CFG_WAVE_TYPE:      cfg_model.wave_type = cfg_wdata[2:0];
          hwb_pkg::CFG_PHASE_OFFSET:   cfg_model.phase_offset = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the wavetable builder testbench: clock, reset, request and register
// stimulus, verdict. Depends on hwb_pkg, hwb_checker and the block's top.
module testbench;

  localparam int TD          = 1024;
  localparam int CYCLE_LIMIT = 40_000_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_kind = hwb_pkg::KIND_READ;
  logic [10:0]       in_read_index = '0;
  logic              out_valid;
  logic signed [15:0] out_sample;
  logic              out_status;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = hwb_pkg::CFG_HARMONIC_COUNT;
  logic [15:0]       cfg_wdata = '0;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                sent = 0;

  harmonic_wavetable_builder_top #(.TABLE_DEPTH(TD), .SINE_ROM_DEPTH(1024)) u_dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_read_index,
    .out_valid, .out_sample, .out_status, .cfg_we, .cfg_index, .cfg_wdata
  );

  hwb_checker #(.TABLE_DEPTH(TD), .SINE_ROM_DEPTH(1024)) u_checker (
    .clk, .rst_n, .start, .busy, .in_kind, .in_read_index,
    .out_valid, .out_sample, .out_status, .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one request; start stays high afterwards so bursts run back to back
  task automatic issue(logic kind, logic [10:0] idx);
    logic taken;
    start <= 1'b1;
    in_kind <= kind;
    in_read_index <= idx;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Let every outstanding request finish before touching registers
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [7:0] count, logic [2:0] wtype, logic [15:0] phase);
    settle();
    write_reg(hwb_pkg::CFG_HARMONIC_COUNT, {8'd0, count});
    write_reg(hwb_pkg::CFG_WAVE_TYPE, {13'd0, wtype});
    write_reg(hwb_pkg::CFG_PHASE_OFFSET, phase);
    @(negedge clk);
  endtask

  function automatic logic [10:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 11'($urandom_range(TD + 1, 2047));
    if ($urandom_range(0, 15) == 0) return 11'(TD);
    return 11'($urandom_range(0, TD - 1));
  endfunction

  // Read the ends and the middle of the table and an index beyond its end
  task automatic read_edges();
    issue(hwb_pkg::KIND_READ, 11'd0);
    issue(hwb_pkg::KIND_READ, 11'd1);
    issue(hwb_pkg::KIND_READ, 11'd512);
    issue(hwb_pkg::KIND_READ, 11'(TD));
    issue(hwb_pkg::KIND_READ, 11'd2047);
  endtask

  initial begin
    logic [2:0] wt;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset contents, then each wave type, an unsupported one included
    issue(hwb_pkg::KIND_READ, 11'd0);
    issue(hwb_pkg::KIND_READ, 11'(TD));
    configure(8'd255, hwb_pkg::WAVE_SINE, 16'd0);
    issue(hwb_pkg::KIND_BUILD, 11'd0);
    read_edges();
    configure(8'd1, hwb_pkg::WAVE_SAW, 16'hFFFF);
    issue(hwb_pkg::KIND_BUILD, 11'h7FF);
    read_edges();
    configure(8'd0, hwb_pkg::WAVE_SAW, 16'h4000);
    issue(hwb_pkg::KIND_BUILD, 11'd0);
    issue(hwb_pkg::KIND_READ, 11'd3);
    configure(8'd3, hwb_pkg::WAVE_SQUARE, 16'd0);
    issue(hwb_pkg::KIND_BUILD, 11'd0);
    issue(hwb_pkg::KIND_READ, 11'd100);
    configure(8'd255, 3'd7, 16'h8000);
    issue(hwb_pkg::KIND_BUILD, 11'd0);
    issue(hwb_pkg::KIND_READ, 11'(TD));
    configure(8'd4, hwb_pkg::WAVE_BUZZ, 16'h1234);
    issue(hwb_pkg::KIND_BUILD, 11'd0);
    read_edges();

    // Random phases: new settings, a build, then read bursts with rare rebuilds
    while (sent < 800) begin
      wt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      configure(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 3)),
                wt, 16'($urandom));
      if (wt == hwb_pkg::WAVE_SAW || wt == hwb_pkg::WAVE_SQUARE)
        if (u_checker.cfg_model.harmonic_count > 4)
          write_reg(hwb_pkg::CFG_HARMONIC_COUNT, 16'd2);
      issue(hwb_pkg::KIND_BUILD, 11'($urandom));
      repeat ($urandom_range(40, 70)) begin
        if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
        if ($urandom_range(0, 99) == 0 &&
            (wt == hwb_pkg::WAVE_SINE || wt > hwb_pkg::WAVE_BUZZ))
          issue(hwb_pkg::KIND_BUILD, 11'($urandom));
        else
          issue(hwb_pkg::KIND_READ, pick_index());
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/hwb_pkg.sv
design/hwb_sine_rom.sv
design/hwb_div.sv
design/hwb_dpath.sv
design/hwb_ctrl.sv
design/harmonic_wavetable_builder_top.sv
bench/hwb_checker.sv
bench/testbench.sv
